@@ rtl/assert_macros.svh @@
// Assertion macros used by the top-level RTL file.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// The antecedent implies the consequent in the same cycle.
`define ASSERT_SAME(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |-> (cons)) \
        else $error("same-cycle check failed");

// The antecedent implies the consequent in the next cycle.
`define ASSERT_NEXT(label, clk, rst_n, ante, cons) \
    label: assert property (@(posedge clk) disable iff (!rst_n) (ante) |=> (cons)) \
        else $error("next-cycle check failed");

`endif

@@ rtl/trf_pkg.sv @@
// Package with constants, types and decode functions of the text run finder.
package trf_pkg;

    localparam int OFFSET_BITS = 24;
    localparam int END_BITS    = OFFSET_BITS + 1;
    localparam int NUM_TAKES   = 5;
    localparam int NUM_RESULTS = 6;

    localparam logic [1:0] MODE_ASCII = 2'd0;
    localparam logic [1:0] MODE_UTF8  = 2'd1;

    localparam logic [1:0] REG_TEXT_MODE  = 2'd0;
    localparam logic [1:0] REG_MIN_RUN    = 2'd1;
    localparam logic [1:0] REG_MIN_TERM   = 2'd2;

    localparam logic KIND_CLASS = 1'b0;
    localparam logic KIND_RUN   = 1'b1;

    localparam logic [3:0] CLS_INVALID   = 4'd0;
    localparam logic [3:0] CLS_PRINTABLE = 4'd1;
    localparam logic [3:0] CLS_LF        = 4'd2;
    localparam logic [3:0] CLS_CR        = 4'd3;
    localparam logic [3:0] CLS_TAB       = 4'd4;
    localparam logic [3:0] CLS_SPACE     = 4'd5;
    localparam logic [3:0] CLS_NBSP      = 4'd6;
    localparam logic [3:0] CLS_SHY       = 4'd7;
    localparam logic [3:0] CLS_OTHER_WS  = 4'd8;

    typedef struct packed {
        logic [3:0]             cls;
        logic [OFFSET_BITS-1:0] off;
        logic [7:0]             data;
    } take_t;

    typedef struct packed {
        logic [2:0] g;
        logic [3:0] cls;
        logic       be;
    } head_t;

    typedef struct packed {
        logic                   kind;
        logic [OFFSET_BITS-1:0] byte_offset;
        logic [3:0]             byte_class;
        logic [OFFSET_BITS-1:0] run_start;
        logic [END_BITS-1:0]    run_end;
        logic [OFFSET_BITS-1:0] run_index;
        logic                   last;
    } res_t;

    function automatic logic [3:0] ws_class(input logic [20:0] cp);
        logic [3:0] c;
        c = CLS_INVALID;
        unique case (cp)
            21'h0A:   c = CLS_LF;
            21'h0D:   c = CLS_CR;
            21'h09:   c = CLS_TAB;
            21'h20:   c = CLS_SPACE;
            21'hA0:   c = CLS_NBSP;
            21'hAD:   c = CLS_SHY;
            21'h2060: c = CLS_OTHER_WS;
            default:
            begin
                if ((cp >= 21'h09 && cp <= 21'h0D) || cp == 21'h85 || cp == 21'h1680 ||
                    (cp >= 21'h2000 && cp <= 21'h200A) || cp == 21'h2028 ||
                    cp == 21'h2029 || cp == 21'h202F || cp == 21'h205F || cp == 21'h3000)
                begin
                    c = CLS_OTHER_WS;
                end
            end
        endcase
        return c;
    endfunction

    function automatic logic [3:0] cp_class(input logic [20:0] cp);
        logic [3:0] w;
        logic [3:0] c;
        w = ws_class(cp);
        if (w != CLS_INVALID)
        begin
            c = w;
        end
        else if (cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF))
        begin
            c = CLS_INVALID;
        end
        else if (cp < 21'h20 || (cp >= 21'h7F && cp <= 21'h9F))
        begin
            c = CLS_INVALID;
        end
        else
        begin
            c = CLS_PRINTABLE;
        end
        return c;
    endfunction

    function automatic logic [3:0] ascii_class(input logic [7:0] b);
        logic [3:0] w;
        logic [3:0] c;
        w = ws_class({13'd0, b});
        if (w != CLS_INVALID)
        begin
            c = w;
        end
        else if (b >= 8'h20 && b <= 8'h7E)
        begin
            c = CLS_PRINTABLE;
        end
        else
        begin
            c = CLS_INVALID;
        end
        return c;
    endfunction

    // Decides how many bytes at the head of the window settle and with which class.
    // A group size of zero means the head waits for more bytes.
    function automatic head_t head_decode(input logic [3:0][7:0] w, input logic [2:0] n,
                                          input logic last, input logic [1:0] mode,
                                          input logic odd, input logic at_zero,
                                          input logic be);
        head_t       h;
        logic [2:0]  len;
        logic [20:0] cp;
        logic [20:0] min_cp;
        logic        bad;
        logic [15:0] u0;
        logic [15:0] u1;
        logic        big;
        logic [20:0] sup;
        h.g = 3'd0;
        h.cls = CLS_INVALID;
        h.be = be;
        len = 3'd0;
        cp = 21'd0;
        min_cp = 21'd0;
        bad = 1'b0;
        u0 = 16'd0;
        u1 = 16'd0;
        big = be;
        sup = 21'd0;
        if (mode == MODE_ASCII)
        begin
            h.g = 3'd1;
            h.cls = ascii_class(w[0]);
        end
        else if (mode == MODE_UTF8)
        begin
            if (!w[0][7])
            begin
                h.g = 3'd1;
                h.cls = cp_class({13'd0, w[0]});
            end
            else
            begin
                priority if (w[0][7:5] == 3'b110)
                begin
                    len = 3'd2;
                    cp = {16'd0, w[0][4:0]};
                    min_cp = 21'h80;
                end
                else if (w[0][7:4] == 4'b1110)
                begin
                    len = 3'd3;
                    cp = {17'd0, w[0][3:0]};
                    min_cp = 21'h800;
                end
                else if (w[0][7:3] == 5'b11110)
                begin
                    len = 3'd4;
                    cp = {18'd0, w[0][2:0]};
                    min_cp = 21'h10000;
                end
                else
                begin
                    len = 3'd0;
                end
                if (len == 3'd0)
                begin
                    h.g = 3'd1;
                end
                else
                begin
                    for (int i = 1; i < 4; i++)
                    begin
                        if (3'(i) < len && 3'(i) < n && w[i][7:6] != 2'b10)
                        begin
                            bad = 1'b1;
                        end
                    end
                    if (bad)
                    begin
                        h.g = 3'd1;
                    end
                    else if (n < len)
                    begin
                        h.g = last ? 3'd1 : 3'd0;
                    end
                    else
                    begin
                        for (int i = 1; i < 4; i++)
                        begin
                            if (3'(i) < len)
                            begin
                                cp = {cp[14:0], w[i][5:0]};
                            end
                        end
                        if (cp < min_cp || cp > 21'h10FFFF || (cp >= 21'hD800 && cp <= 21'hDFFF))
                        begin
                            h.g = 3'd1;
                        end
                        else
                        begin
                            h.g = len;
                            h.cls = cp_class(cp);
                        end
                    end
                end
            end
        end
        else
        begin
            if (odd)
            begin
                h.g = 3'd1;
            end
            else if (n < 3'd2)
            begin
                h.g = last ? 3'd1 : 3'd0;
            end
            else
            begin
                if (at_zero)
                begin
                    big = (w[0] == 8'hFE) && (w[1] == 8'hFF);
                end
                h.be = big;
                u0 = big ? {w[0], w[1]} : {w[1], w[0]};
                if (u0 >= 16'hD800 && u0 <= 16'hDBFF)
                begin
                    if (n < 3'd4)
                    begin
                        h.g = last ? 3'd2 : 3'd0;
                    end
                    else
                    begin
                        u1 = big ? {w[2], w[3]} : {w[3], w[2]};
                        if (u1 < 16'hDC00 || u1 > 16'hDFFF)
                        begin
                            h.g = 3'd2;
                        end
                        else
                        begin
                            sup = {1'b0, u0[9:0], u1[9:0]} + 21'h10000;
                            h.g = 3'd4;
                            h.cls = cp_class(sup);
                        end
                    end
                end
                else if (u0 >= 16'hDC00 && u0 <= 16'hDFFF)
                begin
                    h.g = 3'd2;
                end
                else
                begin
                    h.g = 3'd2;
                    h.cls = cp_class({5'd0, u0});
                end
            end
        end
        return h;
    endfunction

endpackage

@@ rtl/trf_in_if.sv @@
// Interface of the byte input channel.
interface trf_in_if;
    logic       valid;
    logic       ready;
    logic [7:0] data_byte;
    logic       is_last;

    modport source (output valid, output data_byte, output is_last, input ready);
    modport sink (input valid, input data_byte, input is_last, output ready);
endinterface

@@ rtl/trf_out_if.sv @@
// Interface of the result output channel.
interface trf_out_if;
    logic                            valid;
    logic                            ready;
    logic                            result_kind;
    logic [trf_pkg::OFFSET_BITS-1:0] byte_offset;
    logic [3:0]                      byte_class;
    logic [trf_pkg::OFFSET_BITS-1:0] run_start;
    logic [trf_pkg::END_BITS-1:0]    run_end;
    logic [trf_pkg::OFFSET_BITS-1:0] run_index;
    logic                            last_of_item;

    modport source (output valid, output result_kind, output byte_offset, output byte_class,
                    output run_start, output run_end, output run_index,
                    output last_of_item, input ready);
    modport sink (input valid, input result_kind, input byte_offset, input byte_class,
                  input run_start, input run_end, input run_index,
                  input last_of_item, output ready);
endinterface

@@ rtl/trf_decode.sv @@
// Byte window decoder: settles the classes of pending bytes for one request.
module trf_decode (
    input  logic [3:0][7:0]                 pend_bytes,
    input  logic [2:0]                      pend_count,
    input  logic [trf_pkg::OFFSET_BITS-1:0] next_offset,
    input  logic                            big_endian,
    input  logic [7:0]                      data_byte,
    input  logic                            is_last,
    input  logic [1:0]                      text_mode,
    output trf_pkg::take_t                  takes [trf_pkg::NUM_TAKES],
    output logic [2:0]                      num_takes,
    output logic [3:0][7:0]                 pend_bytes_next,
    output logic [2:0]                      pend_count_next,
    output logic [trf_pkg::OFFSET_BITS-1:0] next_offset_next,
    output logic                            big_endian_next
);
    import trf_pkg::*;

    logic [3:0][7:0]        win;
    logic [2:0]             cnt;
    logic [OFFSET_BITS-1:0] head;
    logic [2:0]             ntk;
    logic                   stop;
    logic                   be;
    head_t                  h;

    always_comb
    begin
        win = pend_bytes;
        cnt = pend_count;
        head = next_offset - OFFSET_BITS'(pend_count);
        ntk = 3'd0;
        stop = 1'b0;
        be = big_endian;
        h = '0;
        for (int t = 0; t < NUM_TAKES; t++)
        begin
            takes[t] = '0;
        end
        if (cnt >= 3'd4)
        begin
            takes[0] = '{cls: CLS_INVALID, off: head, data: win[0]};
            ntk = 3'd1;
            win = win >> 8;
            cnt = 3'd3;
            head = head + 1'b1;
        end
        win[cnt[1:0]] = data_byte;
        cnt = cnt + 3'd1;
        for (int it = 0; it < 4; it++)
        begin
            if (!stop && cnt != 3'd0)
            begin
                h = head_decode(win, cnt, is_last, text_mode, head[0],
                                head == '0, be);
                be = h.be;
                if (h.g == 3'd0)
                begin
                    stop = 1'b1;
                end
                else
                begin
                    for (int j = 0; j < 4; j++)
                    begin
                        if (3'(j) < h.g && ntk < 3'(NUM_TAKES))
                        begin
                            takes[ntk] = '{cls: h.cls, off: head, data: win[0]};
                            ntk = ntk + 3'd1;
                            win = win >> 8;
                            cnt = cnt - 3'd1;
                            head = head + 1'b1;
                        end
                    end
                end
            end
        end
        num_takes = ntk;
        pend_bytes_next = win;
        pend_count_next = cnt;
        next_offset_next = next_offset + 1'b1;
        big_endian_next = be;
    end

endmodule

@@ rtl/text_run_finder_unit.sv @@
// Top level of the text run finder: input stage, run tracking and result buffer.
//
// The byte_in channel carries one raw byte per request, with is_last marking
// the end of a stream. The result_out channel carries one result per request:
// either the class of a settled byte or the report of a text run. One input
// byte yields zero to six results; the last of them has last_of_item set.
// Configuration goes through cfg_we, cfg_index and cfg_data; the user must
// write it only while the block is idle, which the block does not enforce.
// A write to the text mode drops any bytes still waiting for a decode.
// A byte is taken into the input register, decoded from there once the
// result buffer is free, and its results are loaded into the six-entry
// result buffer. While the receiver is ready the buffer drains one result
// per cycle, and a new byte is decoded in the cycle the buffer hands out its
// final entry, so throughput is one byte per cycle for bytes that give at
// most one result; otherwise the next byte waits for that final entry.
// Reset clears offsets, run state, byte order and the buffer and loads the
// register defaults. When the receiver stalls, the buffer holds its entries
// and the input side stops after one further byte in the input register.
`include "assert_macros.svh"

module text_run_finder_unit (
    input  logic       clk,
    input  logic       rst_n,
    trf_in_if.sink     byte_in,
    trf_out_if.source  result_out,
    input  logic       cfg_we,
    input  logic [1:0] cfg_index,
    input  logic [7:0] cfg_data
);
    import trf_pkg::*;

    logic [1:0]             text_mode_reg;
    logic [7:0]             min_run_reg;
    logic [7:0]             min_term_reg;

    logic                   in_valid_reg;
    logic [7:0]             in_byte_reg;
    logic                   in_last_reg;

    logic [3:0][7:0]        pend_bytes_reg;
    logic [2:0]             pend_count_reg;
    logic [OFFSET_BITS-1:0] next_offset_reg;
    logic                   big_endian_reg;
    logic                   run_open_reg;
    logic [OFFSET_BITS-1:0] run_start_reg;
    logic [OFFSET_BITS-1:0] runs_reg;

    res_t                   res_buf_reg [NUM_RESULTS];
    logic [2:0]             res_cnt_reg;
    logic [2:0]             rd_reg;

    take_t                  takes [NUM_TAKES];
    logic [2:0]             num_takes;
    logic [3:0][7:0]        pend_bytes_next;
    logic [2:0]             pend_count_next;
    logic [OFFSET_BITS-1:0] next_offset_next;
    logic                   big_endian_next;

    logic                   run_open_next;
    logic [OFFSET_BITS-1:0] run_start_next;
    logic [OFFSET_BITS-1:0] runs_next;
    res_t                   res_new [NUM_RESULTS];
    logic [2:0]             res_cnt_next;

    logic                   out_valid;
    logic                   buf_free;
    logic                   advance;
    res_t                   head_res;

    trf_decode u_decode (
        .pend_bytes       (pend_bytes_reg),
        .pend_count       (pend_count_reg),
        .next_offset      (next_offset_reg),
        .big_endian       (big_endian_reg),
        .data_byte        (in_byte_reg),
        .is_last          (in_last_reg),
        .text_mode        (text_mode_reg),
        .takes            (takes),
        .num_takes        (num_takes),
        .pend_bytes_next  (pend_bytes_next),
        .pend_count_next  (pend_count_next),
        .next_offset_next (next_offset_next),
        .big_endian_next  (big_endian_next)
    );

    always_comb
    begin
        logic                   ro;
        logic [OFFSET_BITS-1:0] rs;
        logic [OFFSET_BITS-1:0] rr;
        logic [2:0]             rc;
        logic [OFFSET_BITS-1:0] lm1;
        logic [END_BITS-1:0]    len;
        logic                   report;
        ro = run_open_reg;
        rs = run_start_reg;
        rr = runs_reg;
        rc = 3'd0;
        lm1 = '0;
        len = '0;
        report = 1'b0;
        for (int r = 0; r < NUM_RESULTS; r++)
        begin
            res_new[r] = '0;
        end
        for (int t = 0; t < NUM_TAKES; t++)
        begin
            if (3'(t) < num_takes)
            begin
                if (rc < 3'(NUM_RESULTS))
                begin
                    res_new[rc].kind = KIND_CLASS;
                    res_new[rc].byte_offset = takes[t].off;
                    res_new[rc].byte_class = takes[t].cls;
                    rc = rc + 3'd1;
                end
                if (takes[t].cls != CLS_INVALID)
                begin
                    if (!ro)
                    begin
                        ro = 1'b1;
                        rs = takes[t].off;
                    end
                end
                else if (ro)
                begin
                    ro = 1'b0;
                    lm1 = takes[t].off - rs - 1'b1;
                    len = {1'b0, lm1} + 1'b1;
                    report = (len >= END_BITS'(min_run_reg)) ||
                             ((len >= END_BITS'(min_term_reg)) && takes[t].data == 8'h00);
                    if (report)
                    begin
                        if (rc < 3'(NUM_RESULTS))
                        begin
                            res_new[rc].kind = KIND_RUN;
                            res_new[rc].run_start = rs;
                            res_new[rc].run_end = {1'b0, rs} + len;
                            res_new[rc].run_index = rr;
                            rc = rc + 3'd1;
                        end
                        rr = rr + 1'b1;
                    end
                end
            end
        end
        if (in_last_reg && ro)
        begin
            lm1 = next_offset_next - rs - 1'b1;
            len = {1'b0, lm1} + 1'b1;
            if (len >= END_BITS'(min_run_reg) && rc < 3'(NUM_RESULTS))
            begin
                res_new[rc].kind = KIND_RUN;
                res_new[rc].run_start = rs;
                res_new[rc].run_end = {1'b0, rs} + len;
                res_new[rc].run_index = rr;
                rc = rc + 3'd1;
            end
        end
        if (rc != 3'd0)
        begin
            res_new[rc - 3'd1].last = 1'b1;
        end
        res_cnt_next = rc;
        run_open_next = ro;
        run_start_next = rs;
        runs_next = rr;
    end

    assign out_valid = (rd_reg != res_cnt_reg);
    assign buf_free = !out_valid || (result_out.ready && (rd_reg + 3'd1 == res_cnt_reg));
    assign advance = in_valid_reg && buf_free;
    assign byte_in.ready = !in_valid_reg || advance;

    assign head_res = res_buf_reg[rd_reg];
    assign result_out.valid = out_valid;
    assign result_out.result_kind = head_res.kind;
    assign result_out.byte_offset = head_res.byte_offset;
    assign result_out.byte_class = head_res.byte_class;
    assign result_out.run_start = head_res.run_start;
    assign result_out.run_end = head_res.run_end;
    assign result_out.run_index = head_res.run_index;
    assign result_out.last_of_item = head_res.last;

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            text_mode_reg <= MODE_ASCII;
            min_run_reg <= 8'd5;
            min_term_reg <= 8'd2;
        end
        else if (cfg_we)
        begin
            unique case (cfg_index)
                REG_TEXT_MODE: text_mode_reg <= cfg_data[1:0];
                REG_MIN_RUN:   min_run_reg <= cfg_data;
                REG_MIN_TERM:  min_term_reg <= cfg_data;
                default:       ;
            endcase
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            in_valid_reg <= 1'b0;
        end
        else if (byte_in.valid && byte_in.ready)
        begin
            in_valid_reg <= 1'b1;
        end
        else if (advance)
        begin
            in_valid_reg <= 1'b0;
        end
    end

    always_ff @(posedge clk)
    begin
        if (byte_in.valid && byte_in.ready)
        begin
            in_byte_reg <= byte_in.data_byte;
            in_last_reg <= byte_in.is_last;
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            pend_count_reg <= 3'd0;
            next_offset_reg <= '0;
            big_endian_reg <= 1'b0;
            run_open_reg <= 1'b0;
            run_start_reg <= '0;
            runs_reg <= '0;
        end
        else if (cfg_we && cfg_index == REG_TEXT_MODE)
        begin
            pend_count_reg <= 3'd0;
        end
        else if (advance)
        begin
            if (in_last_reg)
            begin
                pend_count_reg <= 3'd0;
                next_offset_reg <= '0;
                big_endian_reg <= 1'b0;
                run_open_reg <= 1'b0;
                run_start_reg <= '0;
                runs_reg <= '0;
            end
            else
            begin
                pend_count_reg <= pend_count_next;
                next_offset_reg <= next_offset_next;
                big_endian_reg <= big_endian_next;
                run_open_reg <= run_open_next;
                run_start_reg <= run_start_next;
                runs_reg <= runs_next;
            end
        end
    end

    always_ff @(posedge clk)
    begin
        if (advance)
        begin
            pend_bytes_reg <= pend_bytes_next;
            for (int r = 0; r < NUM_RESULTS; r++)
            begin
                res_buf_reg[r] <= res_new[r];
            end
        end
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            res_cnt_reg <= 3'd0;
            rd_reg <= 3'd0;
        end
        else if (advance)
        begin
            res_cnt_reg <= res_cnt_next;
            rd_reg <= 3'd0;
        end
        else if (out_valid && result_out.ready)
        begin
            rd_reg <= rd_reg + 3'd1;
        end
    end

    `ASSERT_SAME(a_rd_in_range, clk, rst_n, 1'b1, rd_reg <= res_cnt_reg)
    `ASSERT_SAME(a_pend_bound, clk, rst_n, 1'b1, pend_count_reg <= 3'd3)
    `ASSERT_NEXT(a_load_count, clk, rst_n, advance, rd_reg == 3'd0 && res_cnt_reg <= 3'd6)
    `ASSERT_SAME(a_no_decode_while_busy, clk, rst_n, advance,
                 !out_valid || (result_out.ready && rd_reg + 3'd1 == res_cnt_reg))

endmodule
